// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL files; qaa_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/qaa_pkg.sv -----
package qaa_pkg;

   localparam int IN_W         = 18;
   localparam int COMP_W       = 22;
   localparam int ANGLE_W      = 16;
   localparam int AXIS_W       = 16;
   localparam int LIMIT_W      = 15;
   localparam int COUNT_W      = 5;
   localparam int GROUP_CNT_W  = 4;
   localparam int MAX_GROUP    = 16;
   localparam int Q_FRAC       = 14;
   localparam int ONE_Q14      = 16384;
   localparam int ANGLE_MAX    = 51472;
   localparam int HALF_PI_Q20  = 1647099;
   localparam int PRESCALE_SH  = 8;
   localparam int ROUND_SH     = 6;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_CNT_W = 5;
   localparam int CORDIC_XY_W  = 26;
   localparam int CORDIC_Z_W   = 25;
   localparam int ROOT_W       = 46;
   localparam int RADICAND_W   = 45;
   localparam int NORM_W       = 23;
   localparam int DIV_W        = 36;
   localparam int DIV_CNT_W    = 6;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = 1;
   localparam int QUEUE_CNT_W  = 2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_ANGLE_LIMIT = 2'd2;

   // One conversion job handed from the front to the back.
   typedef struct packed {
      logic signed [COMP_W-1:0] w;
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
      logic                     norm;
   } qaa_job_type;

   // Arctangent of 2^-i in Q20.
   function automatic logic signed [CORDIC_Z_W-1:0] atan_entry(
      input logic [CORDIC_CNT_W-1:0] i);
      logic signed [CORDIC_Z_W-1:0] v;
      case (i)
         5'd0:  v = 25'sd823550;
         5'd1:  v = 25'sd486170;
         5'd2:  v = 25'sd256879;
         5'd3:  v = 25'sd130396;
         5'd4:  v = 25'sd65451;
         5'd5:  v = 25'sd32757;
         5'd6:  v = 25'sd16383;
         5'd7:  v = 25'sd8192;
         5'd8:  v = 25'sd4096;
         5'd9:  v = 25'sd2048;
         5'd10: v = 25'sd1024;
         5'd11: v = 25'sd512;
         5'd12: v = 25'sd256;
         5'd13: v = 25'sd128;
         5'd14: v = 25'sd64;
         5'd15: v = 25'sd32;
         5'd16: v = 25'sd16;
         5'd17: v = 25'sd8;
         5'd18: v = 25'sd4;
         5'd19: v = 25'sd2;
         5'd20: v = 25'sd1;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/qaa_if.sv -----
// Input channel: one quaternion sample per beat.
interface qaa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qaa_pkg::IN_W-1:0]      quat_w;
   logic signed [qaa_pkg::IN_W-1:0]      quat_x;
   logic signed [qaa_pkg::IN_W-1:0]      quat_y;
   logic signed [qaa_pkg::IN_W-1:0]      quat_z;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// Result channel: one axis-angle result per beat.
interface qaa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [qaa_pkg::ANGLE_W-1:0]          angle;
   logic signed [qaa_pkg::AXIS_W-1:0]    axis_x;
   logic signed [qaa_pkg::AXIS_W-1:0]    axis_y;
   logic signed [qaa_pkg::AXIS_W-1:0]    axis_z;
   logic                                 small_angle;
   logic                                 saturated;
   logic                                 degenerate;
   modport source (output valid, angle, axis_x, axis_y, axis_z, small_angle, saturated,
                   degenerate, input ready);
   modport sink (input valid, angle, axis_x, axis_y, axis_z, small_angle, saturated,
                 degenerate, output ready);
endinterface

// ----- rtl/core/qaa_front.sv -----
module qaa_front (
   input  logic                              clock,
   input  logic                              reset,
   qaa_req_if.sink                           req,
   input  logic                              average_mode,
   input  logic [qaa_pkg::COUNT_W-1:0]       average_count,
   input  logic                              queue_full,
   output logic                              push_valid,
   output qaa_pkg::qaa_job_type              push_data
);

   logic signed [qaa_pkg::COMP_W-1:0] sum_w_ff, sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [qaa_pkg::COMP_W-1:0] sum_w_in, sum_x_in, sum_y_in, sum_z_in;
   logic [qaa_pkg::GROUP_CNT_W-1:0]   count_ff, count_in;
   logic signed [qaa_pkg::COMP_W-1:0] ext_w, ext_x, ext_y, ext_z;
   logic signed [qaa_pkg::COMP_W-1:0] new_w, new_x, new_y, new_z;
   logic [qaa_pkg::COUNT_W-1:0]       group;
   logic [qaa_pkg::COUNT_W-1:0]       count_next;
   logic                              accept;

   // A beat is taken whenever the queue has room for a possible job.
   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign ext_w = qaa_pkg::COMP_W'(req.quat_w);
   assign ext_x = qaa_pkg::COMP_W'(req.quat_x);
   assign ext_y = qaa_pkg::COMP_W'(req.quat_y);
   assign ext_z = qaa_pkg::COMP_W'(req.quat_z);

   assign new_w = sum_w_ff + ext_w;
   assign new_x = sum_x_ff + ext_x;
   assign new_y = sum_y_ff + ext_y;
   assign new_z = sum_z_ff + ext_z;

   // Effective group length: zero acts as one, anything above the maximum as the maximum.
   always_comb begin
      if (average_count == '0) begin
         group = qaa_pkg::COUNT_W'(1);
      end else if (average_count > qaa_pkg::COUNT_W'(qaa_pkg::MAX_GROUP)) begin
         group = qaa_pkg::COUNT_W'(qaa_pkg::MAX_GROUP);
      end else begin
         group = average_count;
      end
   end

   assign count_next = qaa_pkg::COUNT_W'(count_ff) + qaa_pkg::COUNT_W'(1);

   // Classify the beat: direct conversion, partial group, or completed group.
   always_comb begin
      sum_w_in   = sum_w_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      sum_z_in   = sum_z_ff;
      count_in   = count_ff;
      push_valid = 1'b0;
      push_data  = '{w: ext_w, x: ext_x, y: ext_y, z: ext_z,
                     norm: (ext_w > qaa_pkg::COMP_W'(qaa_pkg::ONE_Q14))};
      if (accept) begin
         if (!average_mode) begin
            push_valid = 1'b1;
         end else if (count_next < group) begin
            sum_w_in = new_w;
            sum_x_in = new_x;
            sum_y_in = new_y;
            sum_z_in = new_z;
            count_in = count_next[qaa_pkg::GROUP_CNT_W-1:0];
         end else begin
            push_valid = 1'b1;
            push_data  = '{w: new_w, x: new_x, y: new_y, z: new_z, norm: 1'b1};
            sum_w_in   = '0;
            sum_x_in   = '0;
            sum_y_in   = '0;
            sum_z_in   = '0;
            count_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_w_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         count_ff <= '0;
      end else begin
         sum_w_ff <= sum_w_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/qaa_fifo.sv -----
module qaa_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  qaa_pkg::qaa_job_type   push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output qaa_pkg::qaa_job_type   pop_data
);

   qaa_pkg::qaa_job_type                entry_ff [qaa_pkg::QUEUE_DEPTH];
   logic [qaa_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [qaa_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [qaa_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                do_push, do_pop;

   assign full      = (count_ff == qaa_pkg::QUEUE_CNT_W'(qaa_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/qaa_back.sv -----
`include "assert_macros.svh"

module qaa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   input  qaa_pkg::qaa_job_type              job,
   output logic                              pop,
   input  logic [qaa_pkg::LIMIT_W-1:0]       small_angle_limit,
   qaa_rsp_if.source                         rsp
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SQUARE = 4'd1;
   localparam logic [3:0] S_NSQRT  = 4'd2;
   localparam logic [3:0] S_NDIV   = 4'd3;
   localparam logic [3:0] S_SPREP  = 4'd4;
   localparam logic [3:0] S_SSQRT  = 4'd5;
   localparam logic [3:0] S_CORDIC = 4'd6;
   localparam logic [3:0] S_ADIV   = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   localparam int SQ_W = 2 * qaa_pkg::COMP_W;
   localparam int WC_W = qaa_pkg::AXIS_W;
   localparam int ROUND_SH_W = qaa_pkg::ROUND_SH;
   localparam logic [qaa_pkg::ROOT_W-1:0] ROOT_START =
      qaa_pkg::ROOT_W'(1) << (qaa_pkg::ROOT_W - 2);

   logic [3:0]                               state_ff, state_in;
   logic signed [qaa_pkg::COMP_W-1:0]        comp_ff [4];
   logic signed [qaa_pkg::COMP_W-1:0]        comp_in [4];
   logic [1:0]                               idx_ff, idx_in;
   logic [qaa_pkg::RADICAND_W-1:0]           acc_ff, acc_in;
   logic [qaa_pkg::RADICAND_W-1:0]           root_v_ff, root_v_in;
   logic [qaa_pkg::ROOT_W-1:0]               root_r_ff, root_r_in;
   logic [qaa_pkg::ROOT_W-1:0]               root_b_ff, root_b_in;
   logic [qaa_pkg::DIV_W-1:0]                div_num_ff, div_num_in;
   logic [qaa_pkg::NORM_W-1:0]               div_rem_ff, div_rem_in;
   logic [qaa_pkg::NORM_W-1:0]               div_den_ff, div_den_in;
   logic [qaa_pkg::DIV_CNT_W-1:0]            div_cnt_ff, div_cnt_in;
   logic                                     div_neg_ff, div_neg_in;
   logic                                     div_load_ff, div_load_in;
   logic signed [WC_W-1:0]                   wc_ff, wc_in;
   logic [qaa_pkg::LIMIT_W-1:0]              s_ff, s_in;
   logic                                     small_ff, small_in;
   logic                                     sat_ff, sat_in;
   logic                                     degen_ff, degen_in;
   logic signed [qaa_pkg::CORDIC_XY_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic signed [qaa_pkg::CORDIC_Z_W-1:0]    cz_ff, cz_in;
   logic [qaa_pkg::CORDIC_CNT_W-1:0]         cor_cnt_ff, cor_cnt_in;
   logic [qaa_pkg::ANGLE_W-1:0]              angle_ff, angle_in;

   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [qaa_pkg::ANGLE_W-1:0]              rsp_angle_ff;
   logic signed [qaa_pkg::AXIS_W-1:0]        rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                                     rsp_small_ff, rsp_sat_ff, rsp_degen_ff;
   logic                                     load_rsp;

   // Shared datapath signals.
   logic signed [qaa_pkg::COMP_W-1:0]        comp_sel, comp_abs;
   logic signed [SQ_W-1:0]                   sq_prod;
   logic [qaa_pkg::RADICAND_W-1:0]           sq_sum;
   logic [qaa_pkg::ROOT_W-1:0]               root_rb, root_r_next, root_b_next;
   logic [qaa_pkg::RADICAND_W-1:0]           root_v_next;
   logic                                     root_ge, root_last;
   logic [qaa_pkg::NORM_W:0]                 div_trial;
   logic                                     div_ge, div_last;
   logic [qaa_pkg::NORM_W-1:0]               div_rem_next;
   logic [qaa_pkg::DIV_W-1:0]                div_num_next;
   logic signed [qaa_pkg::DIV_W:0]           quot_signed;
   logic [qaa_pkg::AXIS_W:0]                 quot_sat;
   logic [qaa_pkg::AXIS_W:0]                 sat_x, sat_y, sat_z;
   logic signed [WC_W-1:0]                   wc_clamp;
   logic signed [2*WC_W-1:0]                 wc_sq;
   logic [qaa_pkg::Q_FRAC*2:0]               s_radicand;
   logic [qaa_pkg::LIMIT_W-1:0]              s_next;
   logic signed [qaa_pkg::CORDIC_XY_W-1:0]   cor_dx, cor_dy;
   logic signed [qaa_pkg::CORDIC_XY_W-1:0]   cx_next, cy_next;
   logic signed [qaa_pkg::CORDIC_Z_W-1:0]    cz_next;
   logic [qaa_pkg::CORDIC_Z_W-1:0]           cz_round;
   logic [qaa_pkg::CORDIC_Z_W-ROUND_SH_W-1:0] ang_wide;
   logic [qaa_pkg::ANGLE_W-1:0]              ang_final;

   // Saturate a signed quotient to the axis range; the top bit flags a clip.
   function automatic logic [qaa_pkg::AXIS_W:0] sat_axis(
      input logic signed [qaa_pkg::DIV_W:0] v);
      logic [qaa_pkg::AXIS_W:0] r;
      if (v > (qaa_pkg::DIV_W + 1)'(32767)) begin
         r = {1'b1, 16'sh7FFF};
      end else if (v < -(qaa_pkg::DIV_W + 1)'(32768)) begin
         r = {1'b1, 16'sh8000};
      end else begin
         r = {1'b0, v[qaa_pkg::AXIS_W-1:0]};
      end
      return r;
   endfunction

   // Component square for the norm.
   assign comp_sel = comp_ff[idx_ff];
   assign comp_abs = comp_sel[qaa_pkg::COMP_W-1] ? -comp_sel : comp_sel;
   assign sq_prod  = comp_sel * comp_sel;
   assign sq_sum   = acc_ff + qaa_pkg::RADICAND_W'(unsigned'(sq_prod));

   // Bit-pair square root, one result bit per cycle.
   assign root_rb     = root_r_ff + root_b_ff;
   assign root_ge     = {1'b0, root_v_ff} >= root_rb;
   assign root_v_next = root_ge ? root_v_ff - root_rb[qaa_pkg::RADICAND_W-1:0] : root_v_ff;
   assign root_r_next = root_ge ? (root_r_ff >> 1) + root_b_ff : root_r_ff >> 1;
   assign root_b_next = root_b_ff >> 2;
   assign root_last   = root_b_ff[0];

   // Restoring divider, one quotient bit per cycle.
   assign div_trial    = {div_rem_ff, div_num_ff[qaa_pkg::DIV_W-1]};
   assign div_ge       = div_trial >= {1'b0, div_den_ff};
   assign div_rem_next = div_ge ? qaa_pkg::NORM_W'(div_trial - {1'b0, div_den_ff})
                                : div_trial[qaa_pkg::NORM_W-1:0];
   assign div_num_next = {div_num_ff[qaa_pkg::DIV_W-2:0], div_ge};
   assign div_last     = (div_cnt_ff == qaa_pkg::DIV_CNT_W'(qaa_pkg::DIV_W - 1));
   assign quot_signed  = div_neg_ff ? -$signed({1'b0, div_num_next})
                                    : $signed({1'b0, div_num_next});
   assign quot_sat     = sat_axis(quot_signed);

   // Undivided axis path.
   assign sat_x = sat_axis((qaa_pkg::DIV_W + 1)'(comp_ff[1]));
   assign sat_y = sat_axis((qaa_pkg::DIV_W + 1)'(comp_ff[2]));
   assign sat_z = sat_axis((qaa_pkg::DIV_W + 1)'(comp_ff[3]));

   // Clamp w to one and form the radicand of the axis scale.
   always_comb begin
      if (comp_ff[0] > qaa_pkg::COMP_W'(qaa_pkg::ONE_Q14)) begin
         wc_clamp = WC_W'(qaa_pkg::ONE_Q14);
      end else if (comp_ff[0] < -qaa_pkg::COMP_W'(qaa_pkg::ONE_Q14)) begin
         wc_clamp = -WC_W'(qaa_pkg::ONE_Q14);
      end else begin
         wc_clamp = comp_ff[0][WC_W-1:0];
      end
   end
   assign wc_sq      = wc_clamp * wc_clamp;
   assign s_radicand = (qaa_pkg::Q_FRAC*2 + 1)'(1 << (qaa_pkg::Q_FRAC*2))
                       - wc_sq[qaa_pkg::Q_FRAC*2:0];
   assign s_next     = root_r_next[qaa_pkg::LIMIT_W-1:0];

   // CORDIC vectoring step.
   assign cor_dx  = cy_ff >>> cor_cnt_ff;
   assign cor_dy  = cx_ff >>> cor_cnt_ff;
   assign cx_next = cy_ff[qaa_pkg::CORDIC_XY_W-1] ? cx_ff - cor_dx : cx_ff + cor_dx;
   assign cy_next = cy_ff[qaa_pkg::CORDIC_XY_W-1] ? cy_ff + cor_dy : cy_ff - cor_dy;
   assign cz_next = cy_ff[qaa_pkg::CORDIC_XY_W-1] ? cz_ff - qaa_pkg::atan_entry(cor_cnt_ff)
                                                  : cz_ff + qaa_pkg::atan_entry(cor_cnt_ff);

   // Angle rounding from Q20 half-angle to Q13 full angle.
   always_comb begin
      cz_round = cz_next[qaa_pkg::CORDIC_Z_W-1] ? '0
                 : unsigned'(cz_next) + qaa_pkg::CORDIC_Z_W'(32);
      ang_wide = cz_round[qaa_pkg::CORDIC_Z_W-1:ROUND_SH_W];
      if (ang_wide > (qaa_pkg::CORDIC_Z_W - ROUND_SH_W)'(qaa_pkg::ANGLE_MAX)) begin
         ang_final = qaa_pkg::ANGLE_W'(qaa_pkg::ANGLE_MAX);
      end else begin
         ang_final = ang_wide[qaa_pkg::ANGLE_W-1:0];
      end
   end

   // Sequencer over the shared root, divider and CORDIC units.
   always_comb begin
      state_in    = state_ff;
      comp_in     = comp_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      root_v_in   = root_v_ff;
      root_r_in   = root_r_ff;
      root_b_in   = root_b_ff;
      div_num_in  = div_num_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      div_cnt_in  = div_cnt_ff;
      div_neg_in  = div_neg_ff;
      div_load_in = div_load_ff;
      wc_in       = wc_ff;
      s_in        = s_ff;
      small_in    = small_ff;
      sat_in      = sat_ff;
      degen_in    = degen_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      cor_cnt_in  = cor_cnt_ff;
      angle_in    = angle_ff;
      pop         = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               pop        = 1'b1;
               comp_in[0] = job.w;
               comp_in[1] = job.x;
               comp_in[2] = job.y;
               comp_in[3] = job.z;
               idx_in     = '0;
               acc_in     = '0;
               sat_in     = 1'b0;
               small_in   = 1'b0;
               degen_in   = 1'b0;
               state_in   = job.norm ? S_SQUARE : S_SPREP;
            end
         end
         S_SQUARE: begin
            acc_in = sq_sum;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 2'd3) begin
               root_v_in = sq_sum;
               root_r_in = '0;
               root_b_in = ROOT_START;
               state_in  = S_NSQRT;
            end
         end
         S_NSQRT: begin
            root_v_in = root_v_next;
            root_r_in = root_r_next;
            root_b_in = root_b_next;
            if (root_last) begin
               if (root_r_next[qaa_pkg::NORM_W-1:0] == '0) begin
                  comp_in[1] = '0;
                  comp_in[2] = '0;
                  comp_in[3] = '0;
                  angle_in   = '0;
                  degen_in   = 1'b1;
                  state_in   = S_OUT;
               end else begin
                  div_den_in  = root_r_next[qaa_pkg::NORM_W-1:0];
                  idx_in      = '0;
                  div_load_in = 1'b1;
                  state_in    = S_NDIV;
               end
            end
         end
         S_NDIV, S_ADIV: begin
            if (div_load_ff) begin
               div_num_in  = {comp_abs, {qaa_pkg::Q_FRAC{1'b0}}};
               div_rem_in  = '0;
               div_cnt_in  = '0;
               div_neg_in  = comp_sel[qaa_pkg::COMP_W-1];
               div_load_in = 1'b0;
            end else begin
               div_num_in = div_num_next;
               div_rem_in = div_rem_next;
               div_cnt_in = div_cnt_ff + 1'b1;
               if (div_last) begin
                  if (state_ff == S_NDIV) begin
                     comp_in[idx_ff] = quot_signed[qaa_pkg::COMP_W-1:0];
                  end else begin
                     comp_in[idx_ff] = qaa_pkg::COMP_W'(
                        signed'(quot_sat[qaa_pkg::AXIS_W-1:0]));
                     sat_in = sat_ff | quot_sat[qaa_pkg::AXIS_W];
                  end
                  if (idx_ff == 2'd3) begin
                     state_in = (state_ff == S_NDIV) ? S_SPREP : S_OUT;
                  end else begin
                     idx_in      = idx_ff + 1'b1;
                     div_load_in = 1'b1;
                  end
               end
            end
         end
         S_SPREP: begin
            wc_in     = wc_clamp;
            root_v_in = qaa_pkg::RADICAND_W'(s_radicand);
            root_r_in = '0;
            root_b_in = ROOT_START;
            state_in  = S_SSQRT;
         end
         S_SSQRT: begin
            root_v_in = root_v_next;
            root_r_in = root_r_next;
            root_b_in = root_b_next;
            if (root_last) begin
               s_in       = s_next;
               small_in   = s_next <= small_angle_limit;
               cor_cnt_in = '0;
               if (!wc_ff[WC_W-1]) begin
                  cx_in = qaa_pkg::CORDIC_XY_W'($signed({wc_ff, {qaa_pkg::PRESCALE_SH{1'b0}}}));
                  cy_in = qaa_pkg::CORDIC_XY_W'({s_next, {qaa_pkg::PRESCALE_SH{1'b0}}});
                  cz_in = '0;
               end else begin
                  cx_in = qaa_pkg::CORDIC_XY_W'({s_next, {qaa_pkg::PRESCALE_SH{1'b0}}});
                  cy_in = qaa_pkg::CORDIC_XY_W'($signed({-wc_ff, {qaa_pkg::PRESCALE_SH{1'b0}}}));
                  cz_in = qaa_pkg::CORDIC_Z_W'(qaa_pkg::HALF_PI_Q20);
               end
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            cx_in      = cx_next;
            cy_in      = cy_next;
            cz_in      = cz_next;
            cor_cnt_in = cor_cnt_ff + 1'b1;
            if (cor_cnt_ff == qaa_pkg::CORDIC_CNT_W'(qaa_pkg::CORDIC_STEPS - 1)) begin
               angle_in = ang_final;
               if (small_ff) begin
                  comp_in[1] = qaa_pkg::COMP_W'(signed'(sat_x[qaa_pkg::AXIS_W-1:0]));
                  comp_in[2] = qaa_pkg::COMP_W'(signed'(sat_y[qaa_pkg::AXIS_W-1:0]));
                  comp_in[3] = qaa_pkg::COMP_W'(signed'(sat_z[qaa_pkg::AXIS_W-1:0]));
                  sat_in     = sat_x[qaa_pkg::AXIS_W] | sat_y[qaa_pkg::AXIS_W]
                               | sat_z[qaa_pkg::AXIS_W];
                  state_in   = S_OUT;
               end else begin
                  idx_in      = 2'd1;
                  div_den_in  = qaa_pkg::NORM_W'(s_ff);
                  div_load_in = 1'b1;
                  state_in    = S_ADIV;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: holds a finished beat while the back starts the next job.
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_load_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_load_ff  <= div_load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff    <= comp_in;
      idx_ff     <= idx_in;
      acc_ff     <= acc_in;
      root_v_ff  <= root_v_in;
      root_r_ff  <= root_r_in;
      root_b_ff  <= root_b_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
      div_neg_ff <= div_neg_in;
      wc_ff      <= wc_in;
      s_ff       <= s_in;
      small_ff   <= small_in;
      sat_ff     <= sat_in;
      degen_ff   <= degen_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      cor_cnt_ff <= cor_cnt_in;
      angle_ff   <= angle_in;
      if (load_rsp) begin
         rsp_angle_ff <= angle_ff;
         rsp_x_ff     <= comp_ff[1][qaa_pkg::AXIS_W-1:0];
         rsp_y_ff     <= comp_ff[2][qaa_pkg::AXIS_W-1:0];
         rsp_z_ff     <= comp_ff[3][qaa_pkg::AXIS_W-1:0];
         rsp_small_ff <= small_ff;
         rsp_sat_ff   <= sat_ff;
         rsp_degen_ff <= degen_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.angle       = rsp_angle_ff;
   assign rsp.axis_x      = rsp_x_ff;
   assign rsp.axis_y      = rsp_y_ff;
   assign rsp.axis_z      = rsp_z_ff;
   assign rsp.small_angle = rsp_small_ff;
   assign rsp.saturated   = rsp_sat_ff;
   assign rsp.degenerate  = rsp_degen_ff;

   // A popped job always leaves idle on the next cycle.
   `ASSERT_NEXT(a_pop_starts_job, clock, reset, pop, state_ff != S_IDLE)
   // The angle never leaves its range.
   `ASSERT_IMPLY(a_angle_range, clock, reset, rsp.valid, rsp.angle <= 16'd51472)
   // A degenerate beat carries no other flag and a zero angle.
   `ASSERT_IMPLY(a_degen_quiet, clock, reset, rsp.valid && rsp.degenerate, rsp.angle == 16'd0 && !rsp.small_angle && !rsp.saturated)

endmodule

// ----- rtl/core/quaternion_to_axis_angle.sv -----
// Converts orientation quaternions (signed Q3.14) to a rotation angle (Q3.13) and a
// saturated axis (Q1.14), either per sample or over groups of averaged samples. The
// front takes one beat per cycle while its two-entry job queue has room; a beat that
// does not close an averaging group makes no job. The back handles a small-angle
// sample without dividing its axis, and divides the axis of any other sample. A job
// that takes a norm first (every averaged group, or a direct sample with w above one)
// divides each component by the norm before that, and a zero-norm group is done once
// its norm is known. The work is done by the single shared restoring divider, the
// bit-pair square-root unit and the 16-step CORDIC for the arccosine; while the output
// register still holds an unaccepted beat, the back waits to finish its job. A
// finished result waits in that output register so the back can start on the next
// job.
module quaternion_to_axis_angle (
   input  logic                                 clock,
   input  logic                                 reset,
   qaa_req_if.sink                              req_bus,
   qaa_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [qaa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [qaa_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   logic                           mode_ff, mode_in;
   logic [qaa_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [qaa_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic                           push_valid, queue_full, job_valid, pop;
   qaa_pkg::qaa_job_type           push_data, job;

   // Configuration register writes.
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      limit_in = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            qaa_pkg::CSR_AVERAGE_MODE:      mode_in  = csr_write_data[0];
            qaa_pkg::CSR_AVERAGE_COUNT:     count_in = csr_write_data[qaa_pkg::COUNT_W-1:0];
            qaa_pkg::CSR_SMALL_ANGLE_LIMIT: limit_in = csr_write_data[qaa_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= qaa_pkg::COUNT_W'(5);
         limit_ff <= qaa_pkg::LIMIT_W'(164);
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

   qaa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .average_mode  (mode_ff),
      .average_count (count_ff),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   qaa_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (job_valid),
      .pop_data   (job)
   );

   qaa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (job_valid),
      .job               (job),
      .pop               (pop),
      .small_angle_limit (limit_ff),
      .rsp               (rsp_bus)
   );

endmodule

// ----- tb/quaternion_to_axis_angle_test.sv -----
module quaternion_to_axis_angle_test;
   timeunit 1ns;
   timeprecision 1ps;

   import qaa_pkg::*;

   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT   = 6000000;

   typedef struct {
      logic signed [IN_W-1:0] w;
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } quat_type;

   typedef struct {
      logic [ANGLE_W-1:0]        angle;
      logic signed [AXIS_W-1:0]  axis_x;
      logic signed [AXIS_W-1:0]  axis_y;
      logic signed [AXIS_W-1:0]  axis_z;
      logic                      small_angle;
      logic                      saturated;
      logic                      degenerate;
   } axis_angle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   qaa_req_if req_bus ();
   qaa_rsp_if rsp_bus ();

   quaternion_to_axis_angle i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Register copies and group sums tracked alongside the block.
   logic                averaging;
   logic [COUNT_W-1:0]  group_length;
   logic [LIMIT_W-1:0]  limit_q14;
   longint              acc_w = 0;
   longint              acc_x = 0;
   longint              acc_y = 0;
   longint              acc_z = 0;
   int                  acc_count = 0;

   quat_type       sample_queue[$];
   axis_angle_type result_queue[$];
   int             error_count = 0;
   int             idle_percent = 34;
   bit             hold_sender = 1'b0;
   int             cycle_count = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint norm4(longint w, longint x, longint y, longint z);
      return longint'(int_sqrt(longint'(w * w + x * x + y * y + z * z)));
   endfunction

   function automatic longint clip_axis(longint v, inout logic sat);
      if (v > 32767) begin
         sat = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         sat = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   // Angle by CORDIC arctangent, axis by division with the small-angle bypass.
   function automatic axis_angle_type axis_angle_of(longint w, longint x, longint y,
                                                    longint z);
      axis_angle_type r;
      longint wc, s, cx, cy, cz, dx, dy, ang, ax, ay, az;
      logic sat;
      wc = w;
      sat = 1'b0;
      if (wc > ONE_Q14) wc = ONE_Q14;
      if (wc < -ONE_Q14) wc = -ONE_Q14;
      s = longint'(int_sqrt(longint'(ONE_Q14) * ONE_Q14 - wc * wc));
      if (wc >= 0) begin
         cx = wc * 256;
         cy = s * 256;
         cz = 0;
      end else begin
         cx = s * 256;
         cy = -wc * 256;
         cz = HALF_PI_Q20;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            cz += atan_entry(CORDIC_CNT_W'(i));
         end else begin
            cx -= dx;
            cy += dy;
            cz -= atan_entry(CORDIC_CNT_W'(i));
         end
      end
      if (cz < 0) cz = 0;
      ang = (cz + 32) >>> 6;
      if (ang > ANGLE_MAX) ang = ANGLE_MAX;
      r.small_angle = (s <= longint'(limit_q14));
      if (r.small_angle) begin
         ax = x;
         ay = y;
         az = z;
      end else begin
         ax = (x * ONE_Q14) / s;
         ay = (y * ONE_Q14) / s;
         az = (z * ONE_Q14) / s;
      end
      r.axis_x = AXIS_W'(clip_axis(ax, sat));
      r.axis_y = AXIS_W'(clip_axis(ay, sat));
      r.axis_z = AXIS_W'(clip_axis(az, sat));
      r.angle = ANGLE_W'(ang);
      r.saturated = sat;
      r.degenerate = 1'b0;
      return r;
   endfunction

   // Advance the tracked state by one sample; returns 1 when a result is due.
   function automatic bit predict_sample(quat_type q, output axis_angle_type r);
      longint w, x, y, z, n;
      int glen;
      w = q.w;
      x = q.x;
      y = q.y;
      z = q.z;
      r = '{default: '0};
      if (!averaging) begin
         if (w > ONE_Q14) begin
            n = norm4(w, x, y, z);
            w = (w * ONE_Q14) / n;
            x = (x * ONE_Q14) / n;
            y = (y * ONE_Q14) / n;
            z = (z * ONE_Q14) / n;
         end
         r = axis_angle_of(w, x, y, z);
         return 1'b1;
      end
      acc_w += w;
      acc_x += x;
      acc_y += y;
      acc_z += z;
      glen = group_length;
      if (glen == 0) glen = 1;
      if (glen > MAX_GROUP) glen = MAX_GROUP;
      if (acc_count + 1 < glen) begin
         acc_count++;
         return 1'b0;
      end
      n = norm4(acc_w, acc_x, acc_y, acc_z);
      if (n == 0) begin
         r.degenerate = 1'b1;
      end else begin
         r = axis_angle_of((acc_w * ONE_Q14) / n, (acc_x * ONE_Q14) / n,
                           (acc_y * ONE_Q14) / n, (acc_z * ONE_Q14) / n);
      end
      acc_w = 0;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      acc_count = 0;
      return 1'b1;
   endfunction

   // Input driver: one sample beat from the pending queue at a time.
   always @(posedge clock) begin
      axis_angle_type r;
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.quat_w <= '0;
         req_bus.quat_x <= '0;
         req_bus.quat_y <= '0;
         req_bus.quat_z <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (predict_sample('{req_bus.quat_w, req_bus.quat_x, req_bus.quat_y,
                                 req_bus.quat_z}, r))
               result_queue.push_back(r);
         end
         if (req_bus.valid && !req_bus.ready) begin
            req_bus.valid <= 1'b1;
         end else if (sample_queue.size() > 0 && !hold_sender &&
                      $urandom_range(99) >= idle_percent) begin
            quat_type q;
            q = sample_queue.pop_front();
            req_bus.valid  <= 1'b1;
            req_bus.quat_w <= q.w;
            req_bus.quat_x <= q.x;
            req_bus.quat_y <= q.y;
            req_bus.quat_z <= q.z;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // Result monitor: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      axis_angle_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (result_queue.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual angle %0d",
                        $time, rsp_bus.angle);
               error_count++;
            end else begin
               e = result_queue.pop_front();
               check_field("angle", e.angle, rsp_bus.angle);
               check_field("axis_x", e.axis_x, rsp_bus.axis_x);
               check_field("axis_y", e.axis_y, rsp_bus.axis_y);
               check_field("axis_z", e.axis_z, rsp_bus.axis_z);
               check_field("small_angle", e.small_angle, rsp_bus.small_angle);
               check_field("saturated", e.saturated, rsp_bus.saturated);
               check_field("degenerate", e.degenerate, rsp_bus.degenerate);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_percent);
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("quaternion_to_axis_angle_test failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (sample_queue.size() > 0 || req_bus.valid || result_queue.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_AVERAGE_MODE:  averaging = data[0];
         CSR_AVERAGE_COUNT: group_length = data[COUNT_W-1:0];
         default:           limit_q14 = data;
      endcase
   endtask

   // Reconfigure only once the block has settled.
   task automatic configure(bit mode, int count, int limit);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_AVERAGE_MODE, CSR_DATA_W'(mode));
      write_register(CSR_AVERAGE_COUNT, CSR_DATA_W'(count));
      write_register(CSR_SMALL_ANGLE_LIMIT, CSR_DATA_W'(limit));
   endtask

   task automatic send(int w, int x, int y, int z);
      sample_queue.push_back('{IN_W'(w), IN_W'(x), IN_W'(y), IN_W'(z)});
   endtask

   function automatic int near_unit(int spread);
      return $urandom_range(2 * spread) - spread;
   endfunction

   // Random sample: mostly plausible orientations, some raw full-range noise.
   function automatic quat_type random_sample();
      quat_type q;
      int kind;
      kind = $urandom_range(9);
      case (kind)
         0, 1: begin
            q.w = IN_W'($urandom);
            q.x = IN_W'($urandom);
            q.y = IN_W'($urandom);
            q.z = IN_W'($urandom);
         end
         2: begin
            q.w = IN_W'(ONE_Q14 - $urandom_range(60));
            q.x = IN_W'(near_unit(200));
            q.y = IN_W'(near_unit(200));
            q.z = IN_W'(near_unit(200));
         end
         3: begin
            q.w = IN_W'(ONE_Q14 + $urandom_range(100000));
            q.x = IN_W'(near_unit(131072));
            q.y = IN_W'(near_unit(131072));
            q.z = IN_W'(near_unit(131072));
         end
         4: begin
            q.w = IN_W'(-ONE_Q14 - $urandom_range(100000));
            q.x = IN_W'(near_unit(300));
            q.y = IN_W'(near_unit(300));
            q.z = IN_W'(near_unit(300));
         end
         default: begin
            q.w = IN_W'(near_unit(ONE_Q14));
            q.x = IN_W'(near_unit(ONE_Q14));
            q.y = IN_W'(near_unit(ONE_Q14));
            q.z = IN_W'(near_unit(ONE_Q14));
         end
      endcase
      return q;
   endfunction

   initial begin
      int count_pick, limit_pick;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      averaging = 1'b0;
      group_length = 5;
      limit_q14 = 164;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Direct mode extremes, identity, both clamps and the normalized path.
      configure(1'b0, 5, 164);
      send(ONE_Q14, 0, 0, 0);
      send(-ONE_Q14, 0, 0, 0);
      send(0, ONE_Q14, 0, 0);
      send(0, 0, 0, 0);
      send(131071, 131071, 131071, 131071);
      send(-131072, -131072, -131072, -131072);
      send(-131072, 131071, -131072, 131071);
      send(131071, -131072, 0, 5);
      send(ONE_Q14 + 1, 3, -3, 7);
      send(16383, 131071, -131072, 100);
      send(0, 131071, -131072, 0);
      configure(1'b0, 5, 0);
      send(ONE_Q14, 5, -5, 1);
      configure(1'b0, 5, 32767);
      send(0, 1000, -1000, 20000);

      // Averaging: cancelling pair, zero and oversized group length, shortened group.
      configure(1'b1, 2, 164);
      send(8000, 100, -100, 50);
      send(-8000, -100, 100, -50);
      configure(1'b1, 0, 164);
      send(9000, 2000, 3000, -4000);
      configure(1'b1, 31, 164);
      for (int i = 0; i < 16; i++) send(131071, 131071, -131072, 131071);
      configure(1'b1, 3, 164);
      send(12000, 500, 600, 700);
      configure(1'b1, 1, 164);
      send(11000, -500, 600, 800);

      // Random phases with a mix of settings, extremes included.
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: count_pick = 1;
            1: count_pick = 16;
            2: count_pick = $urandom_range(31);
            default: count_pick = $urandom_range(2, 8);
         endcase
         case ($urandom_range(4))
            0: limit_pick = 0;
            1: limit_pick = 16384;
            2: limit_pick = 32767;
            3: limit_pick = $urandom_range(32767);
            default: limit_pick = 164;
         endcase
         configure(phase % 2, count_pick, limit_pick);
         idle_percent = (phase == 5) ? 0 : 34;
         for (int i = 0; i < 160; i++) sample_queue.push_back(random_sample());
         if (phase == 3) begin
            while (sample_queue.size() > 80) @(posedge clock);
            hold_sender = 1'b1;
            while (req_bus.valid || result_queue.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("quaternion_to_axis_angle_test passed");
      end else begin
         $display("quaternion_to_axis_angle_test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/qaa_pkg.sv
rtl/core/qaa_if.sv
rtl/core/qaa_front.sv
rtl/core/qaa_fifo.sv
rtl/core/qaa_back.sv
rtl/core/quaternion_to_axis_angle.sv
tb/quaternion_to_axis_angle_test.sv
